### rtl/rtd_pkg.sv
// ----------------------------------------------------------------------------
// rtd_pkg
// Shared types, constants and decode helpers for the Rice tile decoder.
// ----------------------------------------------------------------------------
package rtd_pkg;

   localparam int unsigned CSR_DATA_W = 21;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TILE_PIXELS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COMP_LENGTH = 2'd3;

   localparam logic [16:0] TILE_PIXELS_CAP = 17'd65536;
   localparam logic [21:0] PADDING_BYTES   = 22'd16;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_OVERRUN = 2'd1;
   localparam logic [1:0] ST_SHORT   = 2'd2;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_FIRST,
      PH_FS,
      PH_ZERO,
      PH_SPLIT,
      PH_RAW,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_STEP,
      CTL_FLUSH
   } ctl_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_tile;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] pixel_value;
      logic [6:0]  run_length;
      logic        last_for_byte;
      logic        tile_done;
      logic [1:0]  status;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic step;
      logic flush;
   } ctl_cmd_type;

   typedef struct packed {
      logic can_run;
      logic step_emits;
      logic pend_valid;
   } dp_status_type;

   typedef struct packed {
      phase_type          phase;
      logic [2:0]         hdr_cnt;
      logic [2:0]         raw_cnt;
      logic [31:0]        bit_buf;
      logic signed [6:0]  held;
      logic [31:0]        prev;
      logic [16:0]        pix_done;
      logic [6:0]         block_left;
      logic [4:0]         split;
      logic [31:0]        zero_cnt;
      logic [21:0]        bytes;
      logic [63:0]        raw_acc;
      logic [1:0]         t_code;
      logic [6:0]         t_block;
      logic [16:0]        t_pixels;
      logic [20:0]        t_len;
   } dec_state_type;

   typedef struct packed {
      dec_state_type   st;
      logic            ev;
      rsp_payload_type er;
   } dec_work_type;

   function automatic logic [31:0] low_bits(input logic signed [6:0] n);
      logic [31:0] r;
      if (n <= 7'sd0) begin
         r = '0;
      end else if (n >= 7'sd32) begin
         r = '1;
      end else begin
         r = (32'd1 << n[4:0]) - 32'd1;
      end
      return r;
   endfunction

   function automatic logic [2:0] pix_bytes(input logic [1:0] code);
      return (code == 2'd0) ? 3'd1 : ((code == 2'd1) ? 3'd2 : 3'd4);
   endfunction

   function automatic logic signed [6:0] fs_width(input logic [1:0] code);
      return (code == 2'd0) ? 7'sd3 : ((code == 2'd1) ? 7'sd4 : 7'sd5);
   endfunction

   function automatic logic [4:0] fs_top(input logic [1:0] code);
      return (code == 2'd0) ? 5'd6 : ((code == 2'd1) ? 5'd14 : 5'd25);
   endfunction

   function automatic logic [31:0] pix_mask(input logic [1:0] code);
      return (code == 2'd0) ? 32'h0000_00FF :
             ((code == 2'd1) ? 32'h0000_FFFF : 32'hFFFF_FFFF);
   endfunction

   function automatic logic [5:0] bit_len(input logic [31:0] v);
      logic [5:0] n;
      n = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) n = 6'(i + 1);
      end
      return n;
   endfunction

   function automatic dec_work_type emit(input dec_work_type w, input logic [31:0] pix,
                                         input logic [6:0] run, input logic done,
                                         input logic [1:0] st);
      dec_work_type r;
      r = w;
      r.ev = 1'b1;
      r.er.pixel_value = pix;
      r.er.run_length = run;
      r.er.last_for_byte = 1'b0;
      r.er.tile_done = done;
      r.er.status = st;
      return r;
   endfunction

   function automatic dec_work_type mark_end(input dec_work_type w, input logic [1:0] st);
      dec_work_type r;
      r = w;
      if (r.ev) begin
         r.er.tile_done = 1'b1;
         r.er.status = st;
      end else begin
         r = emit(r, 32'd0, 7'd0, 1'b1, st);
      end
      r.st.phase = PH_DONE;
      return r;
   endfunction

   function automatic dec_work_type put_pixel(input dec_work_type w, input logic [31:0] diff);
      dec_work_type r;
      logic [31:0] d;
      r = w;
      d = (diff >> 1) ^ (32'd0 - {31'd0, diff[0]});
      r.st.prev = (d + r.st.prev) & pix_mask(r.st.t_code);
      r = emit(r, r.st.prev, 7'd1, 1'b0, ST_OK);
      return r;
   endfunction

   function automatic dec_work_type start_block(input dec_work_type w);
      dec_work_type r;
      r = w;
      r.st.held = $signed(r.st.held) - fs_width(r.st.t_code);
      r.st.phase = PH_FS;
      return r;
   endfunction

   function automatic dec_work_type start_pixel(input dec_work_type w);
      dec_work_type r;
      r = w;
      if (r.st.split == fs_top(r.st.t_code)) begin
         r.st.raw_acc = {32'd0, r.st.bit_buf};
         r.st.raw_cnt = '0;
         r.st.phase = PH_RAW;
      end else begin
         r.st.zero_cnt = '0;
         r.st.phase = PH_ZERO;
      end
      return r;
   endfunction

   function automatic dec_work_type end_block(input dec_work_type w);
      dec_work_type r;
      r = w;
      if (r.st.bytes > {1'b0, r.st.t_len}) begin
         r = mark_end(r, ST_OVERRUN);
      end else if (r.st.pix_done >= r.st.t_pixels) begin
         r = mark_end(r, ST_OK);
      end else begin
         r = start_block(r);
      end
      return r;
   endfunction

   function automatic dec_work_type end_pixel(input dec_work_type w);
      dec_work_type r;
      r = w;
      r.st.pix_done = r.st.pix_done + 17'd1;
      if (r.st.block_left != 7'd0) r.st.block_left = r.st.block_left - 7'd1;
      if (r.st.block_left == 7'd0) begin
         r = end_block(r);
      end else begin
         r = start_pixel(r);
      end
      return r;
   endfunction

endpackage

### rtl/rtd_datapath.sv
// ----------------------------------------------------------------------------
// rtd_datapath
// Bit buffer, running pixel, tile counters, registers and the pending result.
// ----------------------------------------------------------------------------
module rtd_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  rtd_pkg::ctl_cmd_type            cmd,
   input  rtd_pkg::req_payload_type        req_payload,
   input  logic                            csr_wr_en,
   input  logic [rtd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rtd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output rtd_pkg::dp_status_type          status,
   output rtd_pkg::rsp_payload_type        pend_result
);

   logic [1:0]               cfg_code_ff;
   logic [6:0]               cfg_block_ff;
   logic [16:0]              cfg_pixels_ff;
   logic [20:0]              cfg_len_ff;
   rtd_pkg::dec_state_type   st_ff;
   rtd_pkg::dec_state_type   st_in;
   rtd_pkg::rsp_payload_type pend_ff;
   rtd_pkg::rsp_payload_type pend_in;
   logic                     pend_v_ff;
   logic                     pend_v_in;
   rtd_pkg::dec_work_type    ld_w;
   rtd_pkg::dec_work_type    sp_w;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_code_ff   <= 2'd1;
         cfg_block_ff  <= 7'd32;
         cfg_pixels_ff <= 17'd1024;
         cfg_len_ff    <= 21'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rtd_pkg::REG_PIXEL_SIZE:  cfg_code_ff   <= csr_wdata[1:0];
            rtd_pkg::REG_BLOCK_SIZE:  cfg_block_ff  <= csr_wdata[6:0];
            rtd_pkg::REG_TILE_PIXELS: cfg_pixels_ff <= csr_wdata[16:0];
            rtd_pkg::REG_COMP_LENGTH: cfg_len_ff    <= csr_wdata[20:0];
            default: ;
         endcase
      end
   end

   // byte intake
   always_comb begin
      logic        skip;
      logic [31:0] diff;
      logic [63:0] shifted;
      ld_w = '0;
      ld_w.st = st_ff;
      skip = 1'b0;
      diff = '0;
      shifted = '0;
      if (req_payload.start_of_tile) begin
         ld_w.st.phase = rtd_pkg::PH_HEADER;
         ld_w.st.hdr_cnt = '0;
      end
      if (ld_w.st.phase != rtd_pkg::PH_DONE) begin
         if (ld_w.st.phase == rtd_pkg::PH_HEADER && ld_w.st.hdr_cnt == 3'd0) begin
            ld_w.st.t_code = (cfg_code_ff > 2'd2) ? 2'd2 : cfg_code_ff;
            ld_w.st.t_block = (cfg_block_ff == 7'd0) ? 7'd1 : cfg_block_ff;
            ld_w.st.t_pixels = (cfg_pixels_ff > rtd_pkg::TILE_PIXELS_CAP) ?
                               rtd_pkg::TILE_PIXELS_CAP : cfg_pixels_ff;
            ld_w.st.t_len = cfg_len_ff;
            ld_w.st.bit_buf = '0;
            ld_w.st.held = '0;
            ld_w.st.prev = '0;
            ld_w.st.pix_done = '0;
            ld_w.st.block_left = '0;
            ld_w.st.split = '0;
            ld_w.st.zero_cnt = '0;
            ld_w.st.bytes = '0;
            if (ld_w.st.t_len < {18'd0, rtd_pkg::pix_bytes(ld_w.st.t_code)}) begin
               ld_w = rtd_pkg::emit(ld_w, 32'd0, 7'd0, 1'b1, rtd_pkg::ST_SHORT);
               ld_w.st.phase = rtd_pkg::PH_DONE;
               skip = 1'b1;
            end
         end
         if (!skip) begin
            ld_w.st.bytes = ld_w.st.bytes + 22'd1;
            if (ld_w.st.phase != rtd_pkg::PH_HEADER &&
                ld_w.st.bytes > ({1'b0, ld_w.st.t_len} + rtd_pkg::PADDING_BYTES)) begin
               ld_w = rtd_pkg::mark_end(ld_w, rtd_pkg::ST_OVERRUN);
            end else begin
               unique case (ld_w.st.phase)
                  rtd_pkg::PH_HEADER: begin
                     ld_w.st.prev = {ld_w.st.prev[23:0], req_payload.data_byte};
                     ld_w.st.hdr_cnt = ld_w.st.hdr_cnt + 3'd1;
                     if (ld_w.st.hdr_cnt >= rtd_pkg::pix_bytes(ld_w.st.t_code)) begin
                        if (ld_w.st.t_pixels == 17'd0) begin
                           ld_w = rtd_pkg::mark_end(ld_w, rtd_pkg::ST_OK);
                        end else begin
                           ld_w.st.phase = rtd_pkg::PH_FIRST;
                        end
                     end
                  end
                  rtd_pkg::PH_FIRST: begin
                     ld_w.st.bit_buf = {24'd0, req_payload.data_byte};
                     ld_w.st.held = 7'sd8;
                     ld_w = rtd_pkg::start_block(ld_w);
                  end
                  rtd_pkg::PH_FS, rtd_pkg::PH_SPLIT: begin
                     ld_w.st.bit_buf = {ld_w.st.bit_buf[23:0], req_payload.data_byte};
                     ld_w.st.held = $signed(ld_w.st.held) + 7'sd8;
                  end
                  rtd_pkg::PH_ZERO: begin
                     ld_w.st.zero_cnt = ld_w.st.zero_cnt +
                                        {{25{ld_w.st.held[6]}}, ld_w.st.held};
                     ld_w.st.bit_buf = {24'd0, req_payload.data_byte};
                     ld_w.st.held = 7'sd8;
                  end
                  rtd_pkg::PH_RAW: begin
                     ld_w.st.raw_acc = {ld_w.st.raw_acc[55:0], req_payload.data_byte};
                     ld_w.st.raw_cnt = ld_w.st.raw_cnt + 3'd1;
                     if (ld_w.st.raw_cnt >= rtd_pkg::pix_bytes(ld_w.st.t_code)) begin
                        shifted = ld_w.st.raw_acc >> ld_w.st.held[5:0];
                        diff = shifted[31:0] & rtd_pkg::pix_mask(ld_w.st.t_code);
                        ld_w.st.bit_buf = ld_w.st.raw_acc[31:0] &
                                          rtd_pkg::low_bits(ld_w.st.held);
                        ld_w = rtd_pkg::put_pixel(ld_w, diff);
                        ld_w = rtd_pkg::end_pixel(ld_w);
                     end
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   // one decode step on buffered bits
   always_comb begin
      logic [31:0] code;
      logic [16:0] left;
      logic [5:0]  len;
      logic [31:0] diff;
      sp_w = '0;
      sp_w.st = st_ff;
      code = '0;
      left = '0;
      len = '0;
      diff = '0;
      unique case (st_ff.phase)
         rtd_pkg::PH_FS: begin
            code = sp_w.st.bit_buf >> sp_w.st.held[5:0];
            left = sp_w.st.t_pixels - sp_w.st.pix_done;
            sp_w.st.bit_buf = sp_w.st.bit_buf & rtd_pkg::low_bits(sp_w.st.held);
            sp_w.st.block_left = ({10'd0, sp_w.st.t_block} < left) ?
                                 sp_w.st.t_block : left[6:0];
            if (code == 32'd0) begin
               sp_w = rtd_pkg::emit(sp_w, sp_w.st.prev, sp_w.st.block_left, 1'b0,
                                    rtd_pkg::ST_OK);
               sp_w.st.pix_done = sp_w.st.pix_done + {10'd0, sp_w.st.block_left};
               sp_w.st.block_left = '0;
               sp_w = rtd_pkg::end_block(sp_w);
            end else begin
               sp_w.st.split = code[4:0] - 5'd1;
               sp_w = rtd_pkg::start_pixel(sp_w);
            end
         end
         rtd_pkg::PH_ZERO: begin
            len = rtd_pkg::bit_len(sp_w.st.bit_buf);
            sp_w.st.zero_cnt = sp_w.st.zero_cnt +
               {{25{sp_w.st.held[6] ^ 1'b0}}, 7'($signed(sp_w.st.held) - $signed({1'b0, len}))};
            sp_w.st.held = $signed({1'b0, len}) - 7'sd1;
            sp_w.st.bit_buf = sp_w.st.bit_buf ^ (32'd1 << sp_w.st.held[4:0]);
            sp_w.st.held = $signed(sp_w.st.held) - $signed({2'b0, sp_w.st.split});
            sp_w.st.phase = rtd_pkg::PH_SPLIT;
         end
         rtd_pkg::PH_SPLIT: begin
            diff = (sp_w.st.zero_cnt << sp_w.st.split) |
                   (sp_w.st.bit_buf >> sp_w.st.held[5:0]);
            sp_w.st.bit_buf = sp_w.st.bit_buf & rtd_pkg::low_bits(sp_w.st.held);
            sp_w = rtd_pkg::put_pixel(sp_w, diff);
            sp_w = rtd_pkg::end_pixel(sp_w);
         end
         default: ;
      endcase
   end

   always_comb begin
      st_in = st_ff;
      pend_in = pend_ff;
      pend_v_in = pend_v_ff;
      if (cmd.load) begin
         st_in = ld_w.st;
         if (ld_w.ev) begin
            pend_in = ld_w.er;
            pend_v_in = 1'b1;
         end
      end else if (cmd.step) begin
         st_in = sp_w.st;
         if (sp_w.ev) begin
            pend_in = sp_w.er;
            pend_v_in = 1'b1;
         end
      end else if (cmd.flush) begin
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // all zero puts the phase at PH_HEADER with no header byte seen
         st_ff <= '0;
         pend_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         pend_v_ff <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

   // a negative count means the field under decode still lacks bits
   logic held_nonneg;
   assign held_nonneg = !st_ff.held[6];

   assign status.can_run = (st_ff.phase == rtd_pkg::PH_FS && held_nonneg) ||
                           (st_ff.phase == rtd_pkg::PH_ZERO && st_ff.bit_buf != 32'd0) ||
                           (st_ff.phase == rtd_pkg::PH_SPLIT && held_nonneg);
   assign status.step_emits = sp_w.ev;
   assign status.pend_valid = pend_v_ff;
   assign pend_result = pend_ff;

endmodule

### rtl/rtd_ctrl.sv
// ----------------------------------------------------------------------------
// rtd_ctrl
// Sequences byte intake, decode steps and result delivery; owns the output
// register.
// ----------------------------------------------------------------------------
module rtd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rtd_pkg::rsp_payload_type rsp_payload,
   input  rtd_pkg::dp_status_type   status,
   input  rtd_pkg::rsp_payload_type pend_result,
   output rtd_pkg::ctl_cmd_type     cmd
);

   rtd_pkg::ctl_state_type   state_ff;
   rtd_pkg::ctl_state_type   state_in;
   logic                     rsp_valid_ff;
   rtd_pkg::rsp_payload_type rsp_data_ff;
   logic                     out_free;
   logic                     push;
   logic                     push_last;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtd_pkg::CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      push = 1'b0;
      push_last = 1'b0;
      unique case (state_ff)
         rtd_pkg::CTL_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = rtd_pkg::CTL_STEP;
            end
         end
         rtd_pkg::CTL_STEP: begin
            if (status.can_run) begin
               // a new result displaces the pending one; hold if nowhere to go
               if (!(status.step_emits && status.pend_valid) || out_free) begin
                  cmd.step = 1'b1;
                  push = status.step_emits && status.pend_valid;
               end
            end else begin
               state_in = rtd_pkg::CTL_FLUSH;
            end
         end
         rtd_pkg::CTL_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = rtd_pkg::CTL_IDLE;
            end else if (out_free) begin
               push = 1'b1;
               push_last = 1'b1;
               cmd.flush = 1'b1;
               state_in = rtd_pkg::CTL_IDLE;
            end
         end
         default: state_in = rtd_pkg::CTL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_data_ff <= {pend_result.pixel_value, pend_result.run_length, push_last,
                         pend_result.tile_done, pend_result.status};
      end
   end

   assign req_stall = (state_ff != rtd_pkg::CTL_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

### rtl/rice_tile_decoder_core.sv
// ----------------------------------------------------------------------------
// rice_tile_decoder_core
// Rice tile decoder: compressed bytes in, decoded pixels and runs out.
//
//   channel  direction  handshake            beat
//   req_     in         req_valid/req_stall  one compressed byte
//   rsp_     out        rsp_valid/rsp_stall  one pixel or run result
//   csr_     in         csr_wr_en            one register write
//
// A byte is loaded, then runs each decode step it triggers (one code, one
// unary scan or one split field each) in the shared step unit, then flushes.
// Results leave through a single output register; a stalled output holds
// the step unit only when a new result would need the pending slot.
// Reset is synchronous; the first byte after reset starts a tile.
// ----------------------------------------------------------------------------
module rice_tile_decoder_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rtd_pkg::req_payload_type        req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rtd_pkg::rsp_payload_type        rsp_payload,
   input  logic                            csr_wr_en,
   input  logic [rtd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rtd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   rtd_pkg::ctl_cmd_type     cmd;
   rtd_pkg::dp_status_type   status;
   rtd_pkg::rsp_payload_type pend_result;

   rtd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .status      (status),
      .pend_result (pend_result)
   );

   rtd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .status      (status),
      .pend_result (pend_result),
      .cmd         (cmd)
   );

endmodule

### tb/sv/rice_tile_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// rice_tile_decoder_core_tb
// Self-checking bench for the Rice tile decoder core. Tiles are streamed a
// byte per beat with random gaps and output stalls. A scoreboard class
// decodes each accepted byte on its own and matches every result beat in
// order. The registers change between tiles to sweep pixel widths, block
// sizes, tile sizes and stream lengths.
// ----------------------------------------------------------------------------
module rice_tile_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 80;
   localparam int RESULT_CAP   = 16;

   typedef bit [7:0] byte_list_type[$];

   class rice_scoreboard;
      bit [31:0] cfg_code = 1, cfg_block = 32, cfg_pixels = 1024, cfg_length = 0;
      bit [31:0] bit_buf, prev_pix, pix_done, blk_left, split, zcount, nbytes;
      bit [31:0] hdr_cnt, raw_cnt, t_code, t_block, t_pixels, t_length;
      bit [63:0] raw_acc;
      int        held;
      rtd_pkg::phase_type phase = rtd_pkg::PH_HEADER;
      rtd_pkg::rsp_payload_type res[RESULT_CAP];
      int        nres;
      rtd_pkg::rsp_payload_type pending[$];
      int        errors, checked, bytes_seen;

      function void write_reg(logic [rtd_pkg::CSR_IDX_W-1:0] idx, bit [31:0] val);
         case (idx)
            rtd_pkg::REG_PIXEL_SIZE:  cfg_code = val & 32'h3;
            rtd_pkg::REG_BLOCK_SIZE:  cfg_block = val & 32'h7F;
            rtd_pkg::REG_TILE_PIXELS: cfg_pixels = val & 32'h1FFFF;
            default:                  cfg_length = val & 32'h1FFFFF;
         endcase
      endfunction

      function bit tile_over();
         return phase == rtd_pkg::PH_DONE;
      endfunction

      function bit [31:0] mask(int n);
         if (n <= 0) return 0;
         if (n >= 32) return 32'hFFFF_FFFF;
         return (32'd1 << n) - 1;
      endfunction

      function int pbytes();
         return t_code == 0 ? 1 : (t_code == 1 ? 2 : 4);
      endfunction

      function void emit(bit [31:0] pix, bit [31:0] run_len, bit done, bit [1:0] st);
         if (nres >= RESULT_CAP) return;
         res[nres] = '{pix, run_len[6:0], 1'b0, done, st};
         nres++;
      endfunction

      function void mark_end(bit [1:0] st);
         if (nres > 0) begin
            res[nres-1].tile_done = 1'b1;
            res[nres-1].status = st;
         end else begin
            emit(0, 0, 1'b1, st);
         end
         phase = rtd_pkg::PH_DONE;
      endfunction

      function void put_pixel(bit [31:0] diff);
         bit [31:0] d;
         d = (diff >> 1) ^ (32'd0 - {31'd0, diff[0]});
         prev_pix = (d + prev_pix) & mask(8 * pbytes());
         emit(prev_pix, 1, 1'b0, rtd_pkg::ST_OK);
      endfunction

      function void start_block();
         held -= (t_code == 0 ? 3 : (t_code == 1 ? 4 : 5));
         phase = rtd_pkg::PH_FS;
      endfunction

      function void start_pixel();
         if (split == (t_code == 0 ? 6 : (t_code == 1 ? 14 : 25))) begin
            raw_acc = {32'd0, bit_buf};
            raw_cnt = 0;
            phase = rtd_pkg::PH_RAW;
         end else begin
            zcount = 0;
            phase = rtd_pkg::PH_ZERO;
         end
      endfunction

      function void end_block();
         if (nbytes > t_length) mark_end(rtd_pkg::ST_OVERRUN);
         else if (pix_done >= t_pixels) mark_end(rtd_pkg::ST_OK);
         else start_block();
      endfunction

      function void end_pixel();
         pix_done++;
         if (blk_left > 0) blk_left--;
         if (blk_left == 0) end_block();
         else start_pixel();
      endfunction

      // Run every decode step the buffered bits allow.
      function void drain_bits();
         bit [31:0] code, left, diff;
         int len;
         forever begin
            if (phase == rtd_pkg::PH_FS && held >= 0) begin
               code = bit_buf >> held;
               left = t_pixels - pix_done;
               bit_buf &= mask(held);
               blk_left = t_block < left ? t_block : left;
               if (code == 0) begin
                  emit(prev_pix, blk_left, 1'b0, rtd_pkg::ST_OK);
                  pix_done += blk_left;
                  blk_left = 0;
                  end_block();
               end else begin
                  split = code - 1;
                  start_pixel();
               end
            end else if (phase == rtd_pkg::PH_ZERO && bit_buf != 0) begin
               len = 0;
               for (int i = 0; i < 32; i++) if (bit_buf[i]) len = i + 1;
               zcount += 32'(held - len);
               held = len - 1;
               bit_buf ^= 32'd1 << held;
               held -= int'(split);
               phase = rtd_pkg::PH_SPLIT;
            end else if (phase == rtd_pkg::PH_SPLIT && held >= 0) begin
               diff = (zcount << split[4:0]) | (bit_buf >> held);
               bit_buf &= mask(held);
               put_pixel(diff);
               end_pixel();
            end else begin
               break;
            end
         end
      endfunction

      function void note_byte(rtd_pkg::req_payload_type p);
         bit [31:0] diff;
         bytes_seen++;
         nres = 0;
         if (p.start_of_tile) begin
            phase = rtd_pkg::PH_HEADER;
            hdr_cnt = 0;
         end
         if (phase == rtd_pkg::PH_DONE) return;
         if (phase == rtd_pkg::PH_HEADER && hdr_cnt == 0) begin
            t_code = cfg_code > 2 ? 2 : cfg_code;
            t_block = cfg_block == 0 ? 1 : cfg_block;
            t_pixels = cfg_pixels > rtd_pkg::TILE_PIXELS_CAP ?
                       rtd_pkg::TILE_PIXELS_CAP : cfg_pixels;
            t_length = cfg_length;
            bit_buf = 0; held = 0; prev_pix = 0; pix_done = 0;
            blk_left = 0; split = 0; zcount = 0; nbytes = 0;
            if (t_length < pbytes()) begin
               emit(0, 0, 1'b1, rtd_pkg::ST_SHORT);
               phase = rtd_pkg::PH_DONE;
               push_results();
               return;
            end
         end
         nbytes++;
         if (phase != rtd_pkg::PH_HEADER && nbytes > t_length + rtd_pkg::PADDING_BYTES) begin
            mark_end(rtd_pkg::ST_OVERRUN);
            push_results();
            return;
         end
         case (phase)
            rtd_pkg::PH_HEADER: begin
               prev_pix = (prev_pix << 8) | p.data_byte;
               hdr_cnt++;
               if (hdr_cnt >= pbytes()) begin
                  if (t_pixels == 0) mark_end(rtd_pkg::ST_OK);
                  else phase = rtd_pkg::PH_FIRST;
               end
            end
            rtd_pkg::PH_FIRST: begin
               bit_buf = p.data_byte;
               held = 8;
               start_block();
            end
            rtd_pkg::PH_FS, rtd_pkg::PH_SPLIT: begin
               bit_buf = (bit_buf << 8) | p.data_byte;
               held += 8;
            end
            rtd_pkg::PH_ZERO: begin
               zcount += 32'(held);
               bit_buf = p.data_byte;
               held = 8;
            end
            rtd_pkg::PH_RAW: begin
               raw_acc = (raw_acc << 8) | p.data_byte;
               raw_cnt++;
               if (raw_cnt >= pbytes()) begin
                  diff = 32'((raw_acc >> held) & {32'd0, mask(8 * pbytes())});
                  bit_buf = 32'(raw_acc & {32'd0, mask(held)});
                  put_pixel(diff);
                  end_pixel();
               end
            end
            default: ;
         endcase
         drain_bits();
         push_results();
      endfunction

      function void push_results();
         if (nres > 0) res[nres-1].last_for_byte = 1'b1;
         for (int i = 0; i < nres; i++) pending.push_back(res[i]);
      endfunction

      function void check_result(rtd_pkg::rsp_payload_type act);
         rtd_pkg::rsp_payload_type exp_r;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result pix=%h run=%0d last=%b done=%b st=%0d",
                     $realtime, act.pixel_value, act.run_length, act.last_for_byte,
                     act.tile_done, act.status);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (act !== exp_r) begin
            $display("%0t: mismatch expected pix=%h run=%0d last=%b done=%b st=%0d",
                     $realtime, exp_r.pixel_value, exp_r.run_length,
                     exp_r.last_for_byte, exp_r.tile_done, exp_r.status);
            $display("%0t:          actual   pix=%h run=%0d last=%b done=%b st=%0d",
                     $realtime, act.pixel_value, act.run_length, act.last_for_byte,
                     act.tile_done, act.status);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rtd_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rtd_pkg::rsp_payload_type rsp_payload;
   logic csr_wr_en = 1'b0;
   logic [rtd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rtd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   rice_scoreboard decoded_pixels = new();
   bit no_idle;
   int cycles;
   int stall_left;

   rice_tile_decoder_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   // Output stall: mostly short bursts, now and then a long one.
   always @(posedge clock) begin
      if (reset || no_idle) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) decoded_pixels.check_result(rsp_payload);
   end

   task automatic send_byte(input bit [7:0] b, input bit sot);
      int gap;
      req_valid <= 1'b1;
      req_payload <= '{b, sot};
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      decoded_pixels.note_byte('{b, sot});
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (decoded_pixels.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input bit [31:0] code, input bit [31:0] blk,
                             input bit [31:0] pix, input bit [31:0] len);
      bit [31:0] vals[4];
      vals = '{code, blk, pix, len};
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= rtd_pkg::CSR_IDX_W'(i);
         csr_wdata <= rtd_pkg::CSR_DATA_W'(vals[i]);
         @(posedge clock);
         decoded_pixels.write_reg(rtd_pkg::CSR_IDX_W'(i), vals[i]);
      end
      csr_wr_en <= 1'b0;
   endtask

   // Send lead bytes, then content and zero padding until tile end or max_fill.
   task automatic play_tile(input bit sot, input byte_list_type lead, input int max_fill,
                            output int sent);
      int n;
      bit [7:0] b;
      sent = 0;
      foreach (lead[i]) begin
         send_byte(lead[i], (i == 0) ? sot : 1'b0);
         sent++;
      end
      n = lead.size();
      while (!decoded_pixels.tile_over() && sent < max_fill) begin
         if (n >= decoded_pixels.cfg_length) b = 8'h00;
         else if ($urandom_range(0, 3) == 0) b = 8'h00;
         else b = 8'($urandom);
         send_byte(b, 1'b0);
         n++;
         sent++;
      end
      repeat ($urandom_range(0, 2)) begin
         send_byte(8'($urandom), 1'b0);
         sent++;
      end
   endtask

   initial begin
      int sent, total, r;
      bit [31:0] code, blk, pix, len;
      byte_list_type lead;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset the defaults give a length shorter than one pixel.
      play_tile(1'b0, '{8'h5A, 8'h11}, 0, sent);
      wait_idle();
      // Two low-entropy blocks close the tile.
      write_regs(0, 4, 8, 12);
      play_tile(1'b1, '{8'hFF, 8'h00}, 30, sent);
      wait_idle();
      // High-entropy block of raw 8-bit differences.
      write_regs(0, 3, 3, 10);
      play_tile(1'b1, '{8'h80, 8'hE0, 8'hA5, 8'h3C, 8'hFF}, 30, sent);
      wait_idle();
      // 32-bit pixels with the widest split code, then a Rice code above fsmax.
      write_regs(2, 2, 4, 40);
      play_tile(1'b1, '{8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'hF8, 8'h00, 8'h01, 8'hD0}, 60, sent);
      wait_idle();
      // Unused size code, zero block size and an empty tile.
      write_regs(3, 0, 0, 8);
      play_tile(1'b1, '{8'h01, 8'h02, 8'h03, 8'h04, 8'h55}, 0, sent);
      wait_idle();
      // Oversized tile runs into the hard overrun on zero padding.
      write_regs(1, 127, 131071, 3);
      play_tile(1'b1, '{8'h12, 8'h34, 8'h7F}, 40, sent);
      wait_idle();
      // Block end overrun and the largest length.
      write_regs(0, 1, 40, 1);
      play_tile(1'b1, '{8'h7F, 8'h00}, 40, sent);
      wait_idle();
      write_regs(0, 64, 5, 2097151);
      play_tile(1'b1, '{8'h00, 8'h3F, 8'hFF}, 40, sent);
      wait_idle();

      total = decoded_pixels.bytes_seen;
      while (total < 110) begin
         no_idle = ($urandom_range(0, 4) == 0);
         code = $urandom_range(0, 3);
         r = $urandom_range(0, 99);
         blk = r < 10 ? $urandom_range(0, 127) : $urandom_range(1, 16);
         r = $urandom_range(0, 99);
         pix = r < 5 ? 0 : (r < 10 ? $urandom_range(65537, 131071) : $urandom_range(1, 48));
         r = $urandom_range(0, 99);
         len = r < 8 ? $urandom_range(0, 3) : (r < 15 ? 2097151 : $urandom_range(4, 40));
         write_regs(code, blk, pix, len);
         lead.delete();
         lead.push_back(8'($urandom));
         play_tile($urandom_range(0, 9) != 0, lead, 60, sent);
         total += sent;
         wait_idle();
      end
      no_idle = 1'b0;
      wait_idle();

      $display("Streamed %0d bytes over directed and random tiles; %0d result beats checked.",
               decoded_pixels.bytes_seen, decoded_pixels.checked);
      if (decoded_pixels.pending.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $realtime,
                  decoded_pixels.pending.size());
         decoded_pixels.errors++;
      end
      if (decoded_pixels.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
